### design/mkds_pkg.sv
// Shared types, codes and constants of the multi-key debounce scanner.
`timescale 1ns / 1ps

package mkds_pkg;

    localparam int NUM_KEYS_DEF = 16;  // default number of key lines
    localparam int KEY_SLOTS    = 16;  // keys that pin_levels can carry

    localparam int PIN_W   = 16;
    localparam int QKEY_W  = 4;
    localparam int CNT_W   = 8;
    localparam int ACT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // Input opcodes carried in s_axis_tuser
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result kinds carried in m_axis_tuser
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_ACTIVE   = 2'd1,
        CFG_INVERT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_QUERY = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch the request, restart the key walk
        logic step;        // commit the current key and advance
        logic sel_query;   // read the stable level at the query index
        logic emit_query;  // load the output with the query answer
        logic emit_last;   // load the output with the held event, marked last
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic key_event;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

### design/mkds_ctrl.sv
// Controller state machine of the debounce scanner: sequences the key walk and the output loads.
`timescale 1ns / 1ps

module mkds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_query,
    output logic              o_in_ready,
    input  mkds_pkg::t_status i_status,
    output mkds_pkg::t_cmd    o_cmd
);

    mkds_pkg::t_state r_state;
    mkds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mkds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mkds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_in_query == mkds_pkg::OP_QUERY) ? mkds_pkg::ST_QUERY
                                                                 : mkds_pkg::ST_SCAN;
                end
            end
            mkds_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = mkds_pkg::ST_FLUSH;
                end else if (!(i_status.key_event && i_status.pend_valid &&
                               !i_status.out_free)) begin
                    // a new event pushes the held one out; hold while that push is due and the output is full
                    o_cmd.step = 1'b1;
                end
            end
            mkds_pkg::ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = mkds_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    n_state = mkds_pkg::ST_IDLE;
                end
            end
            mkds_pkg::ST_QUERY: begin
                o_cmd.sel_query = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.emit_query = 1'b1;
                    n_state = mkds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mkds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/mkds_datapath.sv
// Datapath of the debounce scanner: per-key counters and levels, held event, output register.
`timescale 1ns / 1ps

module mkds_datapath #(
    parameter int NUM_KEYS = mkds_pkg::NUM_KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [mkds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request fields
    input  logic [mkds_pkg::PIN_W-1:0]        i_pins,
    input  logic [mkds_pkg::QKEY_W-1:0]       i_qkey,
    input  mkds_pkg::t_cmd                    i_cmd,
    output mkds_pkg::t_status                 o_status,
    // result register
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_out_kind,
    output logic [mkds_pkg::QKEY_W-1:0]       o_out_key,
    output logic                              o_out_level,
    output logic                              o_out_pressed,
    output logic                              o_out_last
);

    localparam int SLOTS = (NUM_KEYS < mkds_pkg::KEY_SLOTS) ? NUM_KEYS : mkds_pkg::KEY_SLOTS;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW    = mkds_pkg::QKEY_W + 3;  // wide enough to hold NUM_KEYS

    // configuration
    logic [mkds_pkg::CNT_W-1:0]      r_debounce;
    logic [mkds_pkg::ACT_W-1:0]      r_active;
    logic [mkds_pkg::PIN_W-1:0]      r_invert;

    // request and walk
    logic [mkds_pkg::PIN_W-1:0]      r_pins;
    logic [mkds_pkg::QKEY_W-1:0]     r_qkey;
    logic [mkds_pkg::ACT_W-1:0]      r_idx;
    logic [mkds_pkg::ACT_W-1:0]      r_limit;

    // per-key state
    logic                            r_stable [SLOTS];
    logic [mkds_pkg::CNT_W-1:0]      r_cnt    [SLOTS];

    // held event
    logic                            r_pend_valid;
    logic [mkds_pkg::QKEY_W-1:0]     r_pend_key;
    logic                            r_pend_level;

    // output register
    logic                            r_out_valid;
    logic                            r_out_kind;
    logic [mkds_pkg::QKEY_W-1:0]     r_out_key;
    logic                            r_out_level;
    logic                            r_out_pressed;
    logic                            r_out_last;

    logic [IW-1:0]                   rd_idx;
    logic                            rd_stable;
    logic [mkds_pkg::CNT_W-1:0]      cnt_cur;
    logic [mkds_pkg::CNT_W-1:0]      cnt_inc;
    logic                            sample;
    logic                            differ;
    logic                            key_event;
    logic                            out_free;
    logic                            query_level;
    logic [mkds_pkg::QKEY_W-1:0]     cur_key;
    logic [mkds_pkg::ACT_W-1:0]      limit_now;

    assign rd_idx    = i_cmd.sel_query ? r_qkey[IW-1:0] : r_idx[IW-1:0];
    assign rd_stable = r_stable[rd_idx];
    assign cnt_cur   = r_cnt[r_idx[IW-1:0]];
    assign cur_key   = r_idx[mkds_pkg::QKEY_W-1:0];
    assign sample    = r_pins[cur_key];
    assign differ    = (sample != rd_stable);
    assign cnt_inc   = (cnt_cur == {mkds_pkg::CNT_W{1'b1}}) ? cnt_cur
                                                            : cnt_cur + 1'b1;
    assign key_event = differ && (cnt_inc >= r_debounce);
    assign out_free  = !r_out_valid || i_out_ready;
    assign limit_now = (r_active > mkds_pkg::ACT_W'(SLOTS)) ? mkds_pkg::ACT_W'(SLOTS)
                                                           : r_active;
    // keys beyond the configured lines answer idle high
    assign query_level = (KW'(r_qkey) < KW'(NUM_KEYS)) ? rd_stable : 1'b1;

    assign o_status.scan_done  = (r_idx >= r_limit);
    assign o_status.key_event  = key_event;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= mkds_pkg::CNT_W'(3);
            r_active   <= mkds_pkg::ACT_W'(16);
            r_invert   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mkds_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[mkds_pkg::CNT_W-1:0];
                mkds_pkg::CFG_ACTIVE:   r_active   <= i_cfg_data[mkds_pkg::ACT_W-1:0];
                mkds_pkg::CFG_INVERT:   r_invert   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request latch and key walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pins  <= i_pins;
            r_qkey  <= i_qkey;
            r_limit <= limit_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // per-key counters and stable levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_stable[k] <= 1'b1;
                r_cnt[k]    <= '0;
            end
        end else if (i_cmd.step) begin
            if (differ) begin
                r_cnt[r_idx[IW-1:0]] <= cnt_inc;
                if (key_event) begin
                    r_stable[r_idx[IW-1:0]] <= sample;
                end
            end else begin
                r_cnt[r_idx[IW-1:0]] <= '0;
            end
        end
    end

    // held event: kept back until the next one or the end of the walk decides last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && key_event) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.emit_last) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && key_event) begin
            r_pend_key   <= cur_key;
            r_pend_level <= sample;
        end
    end

    // output register
    logic out_load_ev;
    assign out_load_ev = (i_cmd.step && key_event && r_pend_valid) || i_cmd.emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_ev || i_cmd.emit_query) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_query) begin
            r_out_kind    <= mkds_pkg::KIND_QUERY;
            r_out_key     <= r_qkey;
            r_out_level   <= query_level;
            r_out_pressed <= (query_level == r_invert[r_qkey]);
            r_out_last    <= 1'b1;
        end else if (out_load_ev) begin
            r_out_kind    <= mkds_pkg::KIND_EVENT;
            r_out_key     <= r_pend_key;
            r_out_level   <= r_pend_level;
            r_out_pressed <= (r_pend_level == r_invert[r_pend_key]);
            r_out_last    <= i_cmd.emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_key     = r_out_key;
    assign o_out_level   = r_out_level;
    assign o_out_pressed = r_out_pressed;
    assign o_out_last    = r_out_last;

endmodule

### design/multi_key_debounce_scanner.sv
// Top level of the multi-key debounce scanner: stream ports, config port, controller and datapath.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one request: tuser = opcode (scan or query), tdata holds the
//   pin samples and the query index. A scan walks the active keys one per cycle,
//   updates each key's counter and stable level, and sends one event per key
//   whose level changed, in ascending key order; tlast marks the final event.
//   A scan that changes nothing sends no result. A query sends one answer with
//   tlast set.
//   Flow: a request is taken only in the idle state; the per-key walk reads
//   and writes one counter per cycle while it does not hold. Each event is
//   held until the next one is found and then leaves without tlast; the
//   final one leaves with tlast once the walk ends and the flush state loads
//   it into the output register.
//   A result waits in the output register while m_axis_tready is low; the walk
//   holds only when a second event is due and that register is still full, and
//   a query answer or the final event waits for that register to free up.
//   The config port is always ready; the user writes it only while the block idles (not enforced).
//   Reset (synchronous, active low) sets every stable level high, clears all
//   counters and loads the register defaults; no result is pending afterwards.
module multi_key_debounce_scanner #(
    parameter int NUM_KEYS = mkds_pkg::NUM_KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mkds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mkds_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // pin_levels[15:0], query_key[19:16]
    input  logic [0:0]                        s_axis_tuser,   // opcode
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mkds_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // key_index[3:0], level[4], pressed[5]
    output logic [0:0]                        m_axis_tuser,   // result_kind
    output logic                              m_axis_tlast
);

    mkds_pkg::t_cmd                cmd;
    mkds_pkg::t_status             status;
    logic [mkds_pkg::QKEY_W-1:0]   out_key;
    logic                          out_level;
    logic                          out_pressed;
    logic                          out_kind;

    assign o_cfg_ready = 1'b1;

    mkds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_query (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mkds_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pins        (s_axis_tdata[mkds_pkg::PIN_W-1:0]),
        .i_qkey        (s_axis_tdata[mkds_pkg::PIN_W +: mkds_pkg::QKEY_W]),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_kind    (out_kind),
        .o_out_key     (out_key),
        .o_out_level   (out_level),
        .o_out_pressed (out_pressed),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_pressed, out_level, out_key};
    assign m_axis_tuser = out_kind;

endmodule

### design/mkds_checker.sv
// Port-level checker of the debounce scanner, bound to the top level.
`timescale 1ns / 1ps

module mkds_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [mkds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [mkds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [mkds_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input logic [0:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mkds_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [0:0]                        m_axis_tuser,
    input logic                              m_axis_tlast
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a query answer, the only result of its request, always carries tlast
    a_query_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == mkds_pkg::KIND_QUERY) |-> m_axis_tlast)
        else $error("query answer without tlast");

    // one request at a time: busy right after a request is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while still busy");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:6] == 2'b00))
        else $error("nonzero padding in result");

endmodule

bind multi_key_debounce_scanner mkds_checker u_mkds_checker (.*);

### test/tb_multi_key_debounce_scanner.sv
// Testbench of the multi-key debounce scanner: directed and random requests against a local debounce predictor.
`timescale 1ns / 1ps

module tb_multi_key_debounce_scanner;

    localparam int KEYS = 16;

    typedef struct packed {
        logic       kind;
        logic [3:0] key;
        logic       level;
        logic       pressed;
        logic       last;
    } t_key_report;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [mkds_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mkds_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [mkds_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [mkds_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            m_axis_tlast;

    // predictor state and register copies
    logic [KEYS-1:0] key_level;
    logic [7:0]      pred_cnt [KEYS];
    logic [7:0]      cfg_debounce;
    logic [4:0]      cfg_active;
    logic [15:0]     cfg_invert;

    t_key_report key_reports[$];

    int  fail_count;
    int  n_requests;
    int  n_events;
    int  n_answers;
    int  rx_hold;
    logic tx_idle;
    logic rx_idle;

    multi_key_debounce_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Apply one accepted request to the key state and queue the reports it causes.
    function automatic void debounce_apply(input logic op, input logic [15:0] pins,
                                           input logic [3:0] qkey);
        t_key_report batch [KEYS];
        t_key_report r;
        int          n;
        int          cnt;
        if (op == mkds_pkg::OP_QUERY) begin
            r.kind    = mkds_pkg::KIND_QUERY;
            r.key     = qkey;
            r.level   = key_level[qkey];
            r.pressed = (r.level == cfg_invert[qkey]);
            r.last    = 1'b1;
            key_reports.push_back(r);
        end else begin
            n   = (cfg_active > KEYS) ? KEYS : int'(cfg_active);
            cnt = 0;
            for (int i = 0; i < n; i++) begin
                if (pins[i] != key_level[i]) begin
                    if (pred_cnt[i] != 8'hFF)
                        pred_cnt[i] = pred_cnt[i] + 8'd1;
                    if (pred_cnt[i] >= cfg_debounce) begin
                        key_level[i]      = pins[i];
                        r.kind            = mkds_pkg::KIND_EVENT;
                        r.key             = 4'(i);
                        r.level           = pins[i];
                        r.pressed         = (pins[i] == cfg_invert[i]);
                        r.last            = 1'b0;
                        batch[cnt]        = r;
                        cnt++;
                    end
                end else begin
                    pred_cnt[i] = 8'd0;
                end
            end
            if (cnt > 0)
                batch[cnt-1].last = 1'b1;
            for (int i = 0; i < cnt; i++)
                key_reports.push_back(batch[i]);
        end
    endfunction

    // Offer one request after a random gap; keep tvalid high when no gap follows.
    task automatic send_req(input logic op, input logic [15:0] pins, input logic [3:0] qkey);
        int gap;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, qkey, pins};
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        debounce_apply(op, pins, qkey);
        n_requests++;
    endtask

    task automatic send_scan(input logic [15:0] pins);
        send_req(mkds_pkg::OP_SCAN, pins, 4'($urandom));
    endtask

    task automatic send_query(input logic [3:0] qkey);
        send_req(mkds_pkg::OP_QUERY, 16'($urandom), qkey);
    endtask

    // Drop the request, wait for every report, then let a silent scan finish.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (key_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input mkds_pkg::t_cfg_idx idx, input logic [15:0] val);
        settle_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            mkds_pkg::CFG_DEBOUNCE: cfg_debounce = val[7:0];
            mkds_pkg::CFG_ACTIVE:   cfg_active   = val[4:0];
            mkds_pkg::CFG_INVERT:   cfg_invert   = val;
            default: ;
        endcase
    endtask

    // Result side: random stalls per report, long hold-off on request.
    initial begin
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            stall = rx_idle ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready) && rx_hold == 0) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_key_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (key_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d key %0d",
                                          m_axis_tuser, m_axis_tdata[3:0]));
            end else begin
                want = key_reports.pop_front();
                if (m_axis_tuser[0] != want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
                if (m_axis_tdata[3:0] != want.key)
                    report_mismatch($sformatf("key %0d, want %0d", m_axis_tdata[3:0], want.key));
                if (m_axis_tdata[4] != want.level)
                    report_mismatch($sformatf("key %0d level %0d, want %0d",
                                              want.key, m_axis_tdata[4], want.level));
                if (m_axis_tdata[5] != want.pressed)
                    report_mismatch($sformatf("key %0d pressed %0d, want %0d",
                                              want.key, m_axis_tdata[5], want.pressed));
                if (m_axis_tlast != want.last)
                    report_mismatch($sformatf("key %0d tlast %0d, want %0d",
                                              want.key, m_axis_tlast, want.last));
                if (want.kind == mkds_pkg::KIND_EVENT)
                    n_events++;
                else
                    n_answers++;
            end
        end
    end

    // Defaults, then a full debounce on all keys, the immediate flip back and a bounce.
    task automatic test_defaults_and_bounce();
        send_query(4'd0);
        send_query(4'd15);
        repeat (3) send_scan(16'h0000);
        send_scan(16'hFFFF);
        send_scan(16'hFFFF);
        send_scan(16'h5555);
        send_scan(16'hFFFF);
        send_query(4'd7);
    endtask

    task automatic test_threshold_extremes();
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd0);
        send_scan(16'hAAAA);
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd1);
        send_scan(16'hFFFF);
        send_query(4'd2);
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd3);
    endtask

    task automatic test_active_range();
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd1);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd0);
        send_scan(16'h0000);
        send_scan(16'h0000);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd31);
        send_scan(16'h0000);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd1);
        send_scan(16'hFFFF);
        send_scan(16'h0000);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd16);
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd3);
    endtask

    task automatic test_polarity();
        write_reg(mkds_pkg::CFG_INVERT, 16'hFFFF);
        send_query(4'd0);
        send_query(4'd9);
        write_reg(mkds_pkg::CFG_INVERT, 16'hA5C3);
        send_query(4'd3);
        send_query(4'd12);
        repeat (3) send_scan(16'h0F0F);
    endtask

    // Random press episodes held long enough to pass the threshold, with bounce and noise.
    task automatic test_random_episodes(input int n_phases, input int per_phase);
        logic [15:0] cur_pins;
        logic [15:0] target;
        int          items;
        int          hold;
        int          sel;
        cur_pins = key_level;
        for (int p = 0; p < n_phases; p++) begin
            tx_idle = (p % 3) != 1;
            rx_idle = (p % 4) != 1;
            write_reg(mkds_pkg::CFG_DEBOUNCE, 16'($urandom_range(0, 5)));
            write_reg(mkds_pkg::CFG_ACTIVE, 16'($urandom_range(1, 16)));
            write_reg(mkds_pkg::CFG_INVERT, 16'($urandom));
            items = 0;
            while (items < per_phase) begin
                sel = $urandom_range(0, 9);
                if (sel < 2) begin
                    send_query(4'($urandom));
                    items++;
                end else if (sel < 3) begin
                    send_scan(16'($urandom));
                    items++;
                end else begin
                    target = cur_pins;
                    repeat ($urandom_range(1, 4)) target[$urandom_range(0, 15)] ^= 1'b1;
                    hold = int'(cfg_debounce) + $urandom_range(0, 2);
                    if (hold == 0)
                        hold = 1;
                    for (int h = 0; h < hold; h++) begin
                        if ($urandom_range(0, 3) == 0)
                            send_scan(target ^ (16'd1 << $urandom_range(0, 15)));
                        else
                            send_scan(target);
                        items++;
                    end
                    cur_pins = target;
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Hold off the result side while full-width toggles keep coming.
    task automatic test_backpressure();
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd0);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd16);
        write_reg(mkds_pkg::CFG_INVERT, 16'($urandom));
        tx_idle = 1'b0;
        rx_hold = 300;
        for (int k = 0; k < 12; k++)
            send_scan((k % 2) ? 16'hFFFF : 16'h0000);
        settle_idle();
        tx_idle = 1'b1;
    endtask

    // Keep one key differing under the highest threshold: no event may come out.
    task automatic test_high_threshold();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd255);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd2);
        for (int k = 0; k < 20; k++)
            send_scan({14'($urandom), ~key_level[1], key_level[0]});
        send_query(4'd1);
        write_reg(mkds_pkg::CFG_DEBOUNCE, 16'd3);
        write_reg(mkds_pkg::CFG_ACTIVE, 16'd16);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= mkds_pkg::CFG_DEBOUNCE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mkds_pkg::OP_SCAN;
        m_axis_tready <= 1'b0;
        fail_count = 0;
        n_requests = 0;
        n_events   = 0;
        n_answers  = 0;
        rx_hold    = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        key_level    = '1;
        cfg_debounce = 8'd3;
        cfg_active   = 5'd16;
        cfg_invert   = 16'h0000;
        for (int i = 0; i < KEYS; i++)
            pred_cnt[i] = 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_and_bounce();
        test_threshold_extremes();
        test_active_range();
        test_polarity();
        test_random_episodes(4, 25);
        test_backpressure();
        test_high_threshold();
        settle_idle();

        $display("Covered %0d requests: %0d debounce events, %0d query answers checked.",
                 n_requests, n_events, n_answers);
        $display("Thresholds 0..255, 0..31 scanned keys, both polarities, long output stall.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d reports outstanding", key_reports.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
design/mkds_pkg.sv
design/mkds_ctrl.sv
design/mkds_datapath.sv
design/multi_key_debounce_scanner.sv
design/mkds_checker.sv
test/tb_multi_key_debounce_scanner.sv
